### rtl/tksr_pkg.sv
// Shared types, constants and the grid layout function for the top-K severity ranker.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package tksr_pkg;

  localparam int TOP_K      = 10;
  localparam int SLOT_COUNT = 64;

  localparam int SLOT_W  = 6;
  localparam int SCORE_W = 16;
  localparam int RANK_W  = 4;
  localparam int COUNT_W = 4;
  localparam int COLS_W  = 3;
  localparam int ROWS_W  = 2;

  // Internal width of the held count, which must reach TOP_K itself.
  localparam int CNT_W = $clog2(TOP_K + 1);

  typedef struct packed {
    logic [SLOT_W-1:0]         slot;
    logic signed [SCORE_W-1:0] score;
  } tksr_entry_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic shift;
  } tksr_ctl_t;

  typedef struct packed {
    logic [COLS_W-1:0] cols;
    logic [ROWS_W-1:0] rows;
  } tksr_layout_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FINISH,
    ST_EMIT
  } tksr_state_t;

  // Grid layout for a nonzero count of ranked slots.
  function automatic tksr_layout_t tksr_layout(input logic [CNT_W-1:0] n);
    tksr_layout_t l;
    case (n) inside
      CNT_W'(1):                  begin l.cols = COLS_W'(1); l.rows = ROWS_W'(1); end
      [CNT_W'(2) : CNT_W'(4)]:    begin l.cols = COLS_W'(2); l.rows = ROWS_W'(2); end
      [CNT_W'(5) : CNT_W'(6)]:    begin l.cols = COLS_W'(3); l.rows = ROWS_W'(2); end
      [CNT_W'(7) : CNT_W'(9)]:    begin l.cols = COLS_W'(3); l.rows = ROWS_W'(3); end
      default:                    begin l.cols = COLS_W'(5); l.rows = ROWS_W'(2); end
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

### rtl/tksr_cell.sv
// One position of the sorted top-K chain: holds a slot and its severity.
// Depends on tksr_pkg for the entry and command types.
`default_nettype none

module tksr_cell
  import tksr_pkg::*;
(
  input  wire logic        clk,
  input  wire tksr_ctl_t   ctl,
  input  wire logic        occupied,
  input  wire tksr_entry_t new_ent,
  input  wire tksr_entry_t prev_ent,
  input  wire logic        prev_beats,
  input  wire tksr_entry_t next_ent,
  output tksr_entry_t      ent,
  output logic             beats
);

  tksr_entry_t ent_r;
  tksr_entry_t ent_nxt;

  // A strictly greater severity wins, so equal scores keep arrival order.
  assign beats = !occupied || ($signed(new_ent.score) > $signed(ent_r.score));

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.insert && beats) begin
      ent_nxt = prev_beats ? prev_ent : new_ent;
    end else if (ctl.shift) begin
      ent_nxt = next_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

`default_nettype wire

### rtl/top_k_severity_ranker_unit.sv
// Top level of the top-K severity ranker: control, cell chain and result register.
// Depends on tksr_pkg and tksr_cell.
`default_nettype none

// The ranker takes one word per monitored slot and keeps the most severe
// critical slots in a chain of TOP_K cells, sorted most severe first; equal
// severities keep the earlier slot ahead. A slot word is inserted in the cycle
// it is accepted, so a scan streams in at one word per cycle. After the word
// marked scan_end, a finish state latches the count and picks the grid layout,
// and then the chain drains toward its head, one result word per cycle while
// out_stall is low, giving max(n, 1) result words for n held slots; the input
// is stalled in the finish state and during that drain. An empty scan gives
// one word with entry_valid low and the previous layout. Results leave through
// a register, so the last word of a scan may wait while the next scan starts.

module top_k_severity_ranker_unit
  import tksr_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [SLOT_W-1:0]         in_slot_index,
  input  wire logic                      in_is_critical,
  input  wire logic signed [SCORE_W-1:0] in_severity,
  input  wire logic                      in_scan_end,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [RANK_W-1:0]              out_rank,
  output logic [SLOT_W-1:0]              out_ranked_slot,
  output logic                           out_entry_valid,
  output logic [COUNT_W-1:0]             out_critical_count,
  output logic [COLS_W-1:0]              out_grid_cols,
  output logic [ROWS_W-1:0]              out_grid_rows,
  output logic                           out_list_end
);

  tksr_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  held_count_r, held_count_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]  rank_r, rank_nxt;
  tksr_layout_t      layout_r, layout_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [RANK_W-1:0] out_rank_r, out_rank_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic              out_entry_valid_r, out_entry_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  tksr_layout_t      out_layout_r, out_layout_nxt;
  logic              out_list_end_r, out_list_end_nxt;

  logic              in_take;
  logic              slot_ok;
  logic              out_load;
  logic              last_word;
  tksr_ctl_t         ctl;
  tksr_entry_t       new_ent;
  tksr_entry_t       ent [TOP_K];
  logic              beats [TOP_K];

  assign in_take   = in_valid && !in_stall;
  assign slot_ok   = 32'(in_slot_index) < SLOT_COUNT;
  // The result register can take a new word when it is empty or being read.
  assign out_load  = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign last_word = (total_r == '0) || (rank_r == total_r - CNT_W'(1));

  assign new_ent.slot  = in_slot_index;
  assign new_ent.score = in_severity;

  // Outputs of the control: stall and the command for the chain.
  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    ctl.insert = in_take && in_is_critical && slot_ok;
    ctl.shift  = out_load && (total_r != '0);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take && in_scan_end) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load && last_word) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The chain: each cell takes the new entry, its left neighbor's entry when
  // the insertion point lies before it, or its right neighbor's when draining.
  for (genvar i = 0; i < TOP_K; i++) begin : g_cell
    tksr_entry_t prev_e;
    tksr_entry_t next_e;
    logic        prev_b;
    if (i == 0) begin : g_head
      assign prev_e = new_ent;
      assign prev_b = 1'b0;
    end else begin : g_body
      assign prev_e = ent[i-1];
      assign prev_b = beats[i-1];
    end
    if (i == TOP_K - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = ent[i+1];
    end

    tksr_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (CNT_W'(i) < held_count_r),
      .new_ent    (new_ent),
      .prev_ent   (prev_e),
      .prev_beats (prev_b),
      .next_ent   (next_e),
      .ent        (ent[i]),
      .beats      (beats[i])
    );
  end

  // Count, layout and result bookkeeping.
  always_comb begin
    held_count_nxt      = held_count_r;
    total_nxt           = total_r;
    rank_nxt            = rank_r;
    layout_nxt          = layout_r;
    out_valid_nxt       = out_valid_r && out_stall;
    out_rank_nxt        = out_rank_r;
    out_slot_nxt        = out_slot_r;
    out_entry_valid_nxt = out_entry_valid_r;
    out_count_nxt       = out_count_r;
    out_layout_nxt      = out_layout_r;
    out_list_end_nxt    = out_list_end_r;

    if (ctl.insert && (held_count_r < CNT_W'(TOP_K))) begin
      held_count_nxt = held_count_r + CNT_W'(1);
    end

    if (state_r == ST_FINISH) begin
      total_nxt = held_count_r;
      rank_nxt  = '0;
      if (held_count_r != '0) begin
        layout_nxt = tksr_layout(held_count_r);
      end
    end

    if (out_load) begin
      out_valid_nxt       = 1'b1;
      out_rank_nxt        = RANK_W'(rank_r);
      out_slot_nxt        = (total_r != '0) ? ent[0].slot : '0;
      out_entry_valid_nxt = (total_r != '0);
      out_count_nxt       = COUNT_W'(total_r);
      out_layout_nxt      = layout_r;
      out_list_end_nxt    = last_word;
      rank_nxt            = rank_r + CNT_W'(1);
      if (total_r != '0) begin
        held_count_nxt = held_count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      held_count_r <= '0;
      layout_r     <= '{cols: COLS_W'(1), rows: ROWS_W'(1)};
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      held_count_r <= held_count_nxt;
      layout_r     <= layout_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r           <= total_nxt;
    rank_r            <= rank_nxt;
    out_rank_r        <= out_rank_nxt;
    out_slot_r        <= out_slot_nxt;
    out_entry_valid_r <= out_entry_valid_nxt;
    out_count_r       <= out_count_nxt;
    out_layout_r      <= out_layout_nxt;
    out_list_end_r    <= out_list_end_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_rank           = out_rank_r;
  assign out_ranked_slot    = out_slot_r;
  assign out_entry_valid    = out_entry_valid_r;
  assign out_critical_count = out_count_r;
  assign out_grid_cols      = out_layout_r.cols;
  assign out_grid_rows      = out_layout_r.rows;
  assign out_list_end       = out_list_end_r;

`ifndef SYNTH
  // The chain never claims more entries than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_count_r <= CNT_W'(TOP_K))
    else $error("held count exceeds TOP_K");

  // Once the final word of a scan is loaded, the chain has been drained.
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && last_word |=> held_count_r == '0)
    else $error("chain not empty after the final word");

  // The final word of a nonempty list carries the last rank.
  a_last_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_list_end && out_entry_valid |->
      (out_rank == out_critical_count - RANK_W'(1)))
    else $error("final word rank does not match the count");

  // An empty result is always a lone final word with a zero count.
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_valid |-> out_list_end && (out_critical_count == '0))
    else $error("malformed empty result");
`endif

endmodule

`default_nettype wire
